// ----- sv/htp_pkg.sv -----
// ============================================================================
// htp_pkg: shared types and constants for the hall throttle interpreter
// Holds register indexes, result codes, the sequencer states and the
// elaboration-time functions that build the quarter-sine inverse curve.
// ============================================================================
package htp_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_AVG = 2'd2;

    localparam int ZERO_W  = 12;
    localparam int TOL_W   = 10;
    localparam int COUNT_W = 8;
    localparam int M_W     = COUNT_W + 1;

    localparam logic [ZERO_W-1:0]  ZERO_RESET  = 12'd2048;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 10'd50;
    localparam logic [COUNT_W-1:0] SPA_RESET   = 8'd10;

    // Result fields
    localparam int THR_W = 16;
    localparam logic [THR_W-1:0] THR_FULL = 16'hFFFF;

    typedef enum logic [1:0] {
        DIR_NEUTRAL  = 2'd0,
        DIR_FORWARD  = 2'd1,
        DIR_BACKWARD = 2'd2
    } dir_t;

    typedef struct packed {
        dir_t             direction;
        logic [THR_W-1:0] throttle_level;
    } result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_status_t;

    // Shared multiplier: the narrow operand is at most 16 bits wide.
    localparam int MUL_B_W = 16;
    localparam logic [MUL_B_W-1:0] TOL_SCALE = 16'd1000;

    // Restoring divide produces one quotient bit per step.
    localparam int DIV_STEPS  = THR_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    localparam int CURVE_W = 17;
    localparam logic [CURVE_W-1:0] CURVE_TOP = 17'h10000;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_ZMUL,
        SEQ_DIFF,
        SEQ_NMUL,
        SEQ_NCAP,
        SEQ_CMP,
        SEQ_DIV,
        SEQ_PMUL,
        SEQ_LOOK,
        SEQ_TAB,
        SEQ_IMUL,
        SEQ_INTERP,
        SEQ_DONE
    } seq_state_t;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // sin(t * pi/2 / 65536) in Q30 by a seven-term Taylor series, truncating
    // at every step. Only evaluated while building the constant curve.
    function automatic logic signed [63:0] quarter_sine_q30(logic [63:0] t);
        logic [63:0]        a;
        logic [63:0]        a2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        a    = (t * HALF_PI_Q30) >> 16;
        a2   = (a * a) >> 30;
        term = a;
        acc  = signed'(a);
        term = ((term * a2) >> 30) / 64'd6;
        acc  = acc - signed'(term);
        term = ((term * a2) >> 30) / 64'd20;
        acc  = acc + signed'(term);
        term = ((term * a2) >> 30) / 64'd42;
        acc  = acc - signed'(term);
        term = ((term * a2) >> 30) / 64'd72;
        acc  = acc + signed'(term);
        term = ((term * a2) >> 30) / 64'd110;
        acc  = acc - signed'(term);
        term = ((term * a2) >> 30) / 64'd156;
        acc  = acc + signed'(term);
        return acc;
    endfunction

    // Largest t in 0..65536 whose quarter sine does not exceed x (Q30).
    function automatic logic [CURVE_W-1:0] curve_point(logic signed [63:0] x);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        lo = 32'd0;
        hi = 32'd65537;
        for (int s = 0; s < 17; s++)
        begin
            if (hi - lo > 32'd1)
            begin
                mid = (lo + hi) >> 1;
                if (quarter_sine_q30(64'(mid)) <= x)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid;
                end
            end
        end
        return lo[CURVE_W-1:0];
    endfunction

endpackage

// ----- sv/htp_if.sv -----
// ============================================================================
// htp_if: channel interfaces of the hall throttle interpreter
// Sample stream, result stream and configuration write channel, each with
// valid/ready and a source and a sink modport.
// ============================================================================
interface htp_sample_if #(
    parameter int ADC_BITS = 12
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface htp_result_if;
    logic                       valid;
    logic                       ready;
    htp_pkg::dir_t              direction;
    logic [htp_pkg::THR_W-1:0]  throttle_level;

    modport source (output valid, output direction, output throttle_level, input ready);
    modport sink   (input valid, input direction, input throttle_level, output ready);
endinterface

interface htp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [htp_pkg::CFG_IDX_W-1:0]  index;
    logic [htp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/hall_throttle_interpreter.sv -----
// ============================================================================
// hall_throttle_interpreter: hall sensor throttle interpreter
// Sums groups of raw hall samples and reports direction and a Q0.16
// throttle level for each complete group.
// ============================================================================
//
//  Channel   Modport  Payload                        Beat
//  sample    sink     adc_sample                     one raw conversion
//  result    source   direction, throttle_level      one per closed group
//  cfg       sink     index, data                    one register write
//
//  A sample that does not close its group leaves sample.ready high.
//  The closing sample keeps sample.ready low until the result register loads;
//  the sequencer runs the 16-step restoring divide and five passes through
//  the one shared multiplier, or only three passes when the throttle saturates.
//  Reset restores the register defaults and clears the open group; no
//  clearing pass is needed. A result waiting on a stalled sink holds the
//  sequencer, and sample.ready stays low until the result register frees.
//
module hall_throttle_interpreter #(
    parameter int ADC_BITS           = 12,
    parameter int ACOS_TABLE_ENTRIES = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    htp_sample_if.sink    sample,
    htp_result_if.source  result,
    htp_cfg_if.sink       cfg
);

    localparam int SUM_W  = ADC_BITS + 8;
    localparam logic [htp_pkg::ZERO_W-1:0] ZERO_MASK =
        htp_pkg::ZERO_W'((64'd1 << ADC_BITS) - 64'd1);

    logic [htp_pkg::ZERO_W-1:0]  zero_reg, zero_next;
    logic [htp_pkg::TOL_W-1:0]   tol_reg,  tol_next;
    logic [htp_pkg::COUNT_W-1:0] spa_reg,  spa_next;

    logic [SUM_W-1:0]            sample_sum_reg,   sample_sum_next;
    logic [htp_pkg::COUNT_W-1:0] sample_count_reg, sample_count_next;

    logic                        out_valid_reg, out_valid_next;
    htp_pkg::result_t            out_reg,       out_next;

    htp_pkg::seq_status_t        seq_status;
    htp_pkg::result_t            seq_result;

    logic                        sample_fire;
    logic                        cfg_fire;
    logic [SUM_W-1:0]            sum_inc;
    logic [htp_pkg::COUNT_W-1:0] count_inc;
    logic [htp_pkg::M_W-1:0]     group_m;
    logic [htp_pkg::COUNT_W-1:0] group_n;
    logic                        group_close;
    logic                        take;

    assign sample.ready = seq_status.idle;
    assign cfg.ready    = 1'b1;
    assign sample_fire  = sample.valid & sample.ready;
    assign cfg_fire     = cfg.valid & cfg.ready;

    assign sum_inc   = sample_sum_reg + SUM_W'(sample.adc_sample);
    assign count_inc = sample_count_reg + htp_pkg::COUNT_W'(1);
    // A wrapped count of zero stands for 256 samples.
    assign group_m   = {(count_inc == '0), count_inc};
    assign group_n   = (spa_reg == '0) ? htp_pkg::COUNT_W'(1) : spa_reg;
    assign group_close = sample_fire && (group_m >= {1'b0, group_n});

    assign take = seq_status.done && (!out_valid_reg || result.ready);

    htp_seq #(
        .ADC_BITS           (ADC_BITS),
        .ACOS_TABLE_ENTRIES (ACOS_TABLE_ENTRIES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (group_close),
        .start_sum  (sum_inc),
        .start_m    (group_m),
        .zero_level (zero_reg),
        .tolerance  (tol_reg),
        .take       (take),
        .status     (seq_status),
        .result     (seq_result)
    );

    always_comb
    begin
        zero_next = zero_reg;
        tol_next  = tol_reg;
        spa_next  = spa_reg;
        if (cfg_fire)
        begin
            case (cfg.index)
                htp_pkg::REG_ZERO_LEVEL:  zero_next = cfg.data & ZERO_MASK;
                htp_pkg::REG_TOLERANCE:   tol_next  = cfg.data[htp_pkg::TOL_W-1:0];
                htp_pkg::REG_SAMPLES_AVG: spa_next  = cfg.data[htp_pkg::COUNT_W-1:0];
                default:                  zero_next = zero_reg;
            endcase
        end
    end

    always_comb
    begin
        sample_sum_next   = sample_sum_reg;
        sample_count_next = sample_count_reg;
        if (group_close)
        begin
            sample_sum_next   = '0;
            sample_count_next = '0;
        end
        else if (sample_fire)
        begin
            sample_sum_next   = sum_inc;
            sample_count_next = count_inc;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            out_next       = seq_result;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg         <= htp_pkg::ZERO_RESET & ZERO_MASK;
            tol_reg          <= htp_pkg::TOL_RESET;
            spa_reg          <= htp_pkg::SPA_RESET;
            sample_sum_reg   <= '0;
            sample_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            zero_reg         <= zero_next;
            tol_reg          <= tol_next;
            spa_reg          <= spa_next;
            sample_sum_reg   <= sample_sum_next;
            sample_count_reg <= sample_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.direction      = out_reg.direction;
    assign result.throttle_level = out_reg.throttle_level;

    // A closing beat must hand the group to the sequencer and block samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        group_close |=> !sample.ready)
        else $error("sample channel still ready after a group closed");

    // The open group never holds 255 samples: it closes by then at the latest.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_count_reg != '1)
        else $error("sample count ran past the largest group");

    // A finished result waits in the sequencer while the output register is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_status.done && out_valid_reg && !result.ready |=> seq_status.done)
        else $error("sequencer dropped a result while the output was stalled");

    // Loading the output register always leaves a valid beat behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> result.valid && (result.direction == $past(seq_result.direction)))
        else $error("result register did not load the sequencer result");

endmodule

// ----- sv/htp_mul.sv -----
// ============================================================================
// htp_mul: shared registered multiplier
// One unsigned multiply per cycle; the product is registered and available in
// the cycle after the operands are presented.
// ============================================================================
module htp_mul #(
    parameter int A_W = 21,
    parameter int B_W = 16
) (
    input  logic               clk,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);

    logic [A_W+B_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end

    assign p = p_reg;

endmodule

// ----- sv/htp_seq.sv -----
// ============================================================================
// htp_seq: result sequencer
// Works out direction and throttle for one closed group of samples using the
// shared multiplier, a restoring divider and the inverse quarter-sine curve.
// ============================================================================
module htp_seq #(
    parameter int ADC_BITS           = 12,
    parameter int ACOS_TABLE_ENTRIES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ADC_BITS+7:0]           start_sum,
    input  logic [htp_pkg::M_W-1:0]       start_m,
    input  logic [htp_pkg::ZERO_W-1:0]    zero_level,
    input  logic [htp_pkg::TOL_W-1:0]     tolerance,
    input  logic                          take,
    output htp_pkg::seq_status_t          status,
    output htp_pkg::result_t              result
);

    localparam int SUM_W = ADC_BITS + 8;
    localparam int ZM_W  = htp_pkg::ZERO_W + htp_pkg::M_W;
    localparam int V_W   = (SUM_W > ZM_W) ? SUM_W : ZM_W;
    localparam int P_W   = V_W + htp_pkg::MUL_B_W;
    localparam int IDX_W = $clog2(ACOS_TABLE_ENTRIES + 1);
    localparam int CW    = htp_pkg::CURVE_W;
    localparam int TW    = htp_pkg::THR_W;

    // Inverse quarter-sine curve, built at elaboration.
    logic [CW-1:0] curve [0:ACOS_TABLE_ENTRIES];

    for (genvar g = 0; g <= ACOS_TABLE_ENTRIES; g++)
    begin : g_curve
        localparam logic [63:0] X = (64'(g) << 30) / ACOS_TABLE_ENTRIES;
        localparam logic [CW-1:0] POINT = (g == ACOS_TABLE_ENTRIES) ?
            htp_pkg::CURVE_TOP : htp_pkg::curve_point(signed'(X));
        assign curve[g] = POINT;
    end

    htp_pkg::seq_state_t state_reg, state_next;

    logic [SUM_W-1:0]              s_reg,    s_next;
    logic [htp_pkg::M_W-1:0]       m_reg,    m_next;
    logic [V_W-1:0]                z_reg,    z_next;
    logic [V_W-1:0]                d_reg,    d_next;
    logic                          fwd_reg,  fwd_next;
    logic [P_W-1:0]                dk_reg,   dk_next;
    logic [V_W-1:0]                rem_reg,  rem_next;
    logic [TW-1:0]                 q_reg,    q_next;
    logic [htp_pkg::DIV_STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]              idx_reg,  idx_next;
    logic [TW-1:0]                 f_reg,    f_next;
    logic [CW-1:0]                 lo_reg,   lo_next;
    logic [CW-1:0]                 diff_reg, diff_next;
    htp_pkg::dir_t                 dir_reg,  dir_next;
    logic [TW-1:0]                 thr_reg,  thr_next;

    logic [V_W-1:0]              mul_a;
    logic [htp_pkg::MUL_B_W-1:0] mul_b;
    logic [P_W-1:0]              mul_p;

    htp_mul #(
        .A_W (V_W),
        .B_W (htp_pkg::MUL_B_W)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    logic [V_W-1:0] s_ext;
    logic [V_W-1:0] z_new;
    logic [V_W:0]   rem_dbl;
    logic           rem_ge;
    logic [CW-1:0]  hi_point;
    logic [CW:0]    interp_sum;

    assign s_ext   = V_W'(s_reg);
    assign z_new   = mul_p[V_W-1:0];
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_ge  = (rem_dbl >= {1'b0, z_reg});
    assign hi_point   = curve[idx_reg + IDX_W'(1)];
    assign interp_sum = {1'b0, lo_reg} + (CW+1)'(mul_p[CW+TW-1:TW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= htp_pkg::SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        m_reg    <= m_next;
        z_reg    <= z_next;
        d_reg    <= d_next;
        fwd_reg  <= fwd_next;
        dk_reg   <= dk_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        step_reg <= step_next;
        idx_reg  <= idx_next;
        f_reg    <= f_next;
        lo_reg   <= lo_next;
        diff_reg <= diff_next;
        dir_reg  <= dir_next;
        thr_reg  <= thr_next;
    end

    always_comb
    begin
        state_next = state_reg;
        s_next     = s_reg;
        m_next     = m_reg;
        z_next     = z_reg;
        d_next     = d_reg;
        fwd_next   = fwd_reg;
        dk_next    = dk_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        f_next     = f_reg;
        lo_next    = lo_reg;
        diff_next  = diff_reg;
        dir_next   = dir_reg;
        thr_next   = thr_reg;
        mul_a      = '0;
        mul_b      = '0;

        case (state_reg)
            htp_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    s_next     = start_sum;
                    m_next     = start_m;
                    state_next = htp_pkg::SEQ_ZMUL;
                end
            end
            htp_pkg::SEQ_ZMUL:
            begin
                mul_a      = V_W'(zero_level);
                mul_b      = htp_pkg::MUL_B_W'(m_reg);
                state_next = htp_pkg::SEQ_DIFF;
            end
            htp_pkg::SEQ_DIFF:
            begin
                z_next     = z_new;
                fwd_next   = (s_ext > z_new);
                d_next     = (s_ext > z_new) ? s_ext - z_new : z_new - s_ext;
                state_next = htp_pkg::SEQ_NMUL;
            end
            htp_pkg::SEQ_NMUL:
            begin
                mul_a      = d_reg;
                mul_b      = htp_pkg::TOL_SCALE;
                state_next = htp_pkg::SEQ_NCAP;
            end
            htp_pkg::SEQ_NCAP:
            begin
                dk_next    = mul_p;
                mul_a      = z_reg;
                mul_b      = htp_pkg::MUL_B_W'(tolerance);
                state_next = htp_pkg::SEQ_CMP;
            end
            htp_pkg::SEQ_CMP:
            begin
                // The multiplier now holds tolerance times the zero sum.
                if ((d_reg == '0) || (dk_reg < mul_p))
                begin
                    dir_next = htp_pkg::DIR_NEUTRAL;
                end
                else if (fwd_reg)
                begin
                    dir_next = htp_pkg::DIR_FORWARD;
                end
                else
                begin
                    dir_next = htp_pkg::DIR_BACKWARD;
                end
                if (d_reg >= z_reg)
                begin
                    thr_next   = htp_pkg::THR_FULL;
                    state_next = htp_pkg::SEQ_DONE;
                end
                else
                begin
                    rem_next   = d_reg;
                    q_next     = '0;
                    step_next  = '0;
                    state_next = htp_pkg::SEQ_DIV;
                end
            end
            htp_pkg::SEQ_DIV:
            begin
                // Remainder stays below the divisor, so it fits V_W bits.
                if (rem_ge)
                begin
                    rem_next = V_W'(rem_dbl - {1'b0, z_reg});
                end
                else
                begin
                    rem_next = rem_dbl[V_W-1:0];
                end
                q_next    = {q_reg[TW-2:0], rem_ge};
                step_next = step_reg + htp_pkg::DIV_STEP_W'(1);
                if (step_reg == htp_pkg::DIV_STEP_W'(htp_pkg::DIV_STEPS - 1))
                begin
                    state_next = htp_pkg::SEQ_PMUL;
                end
            end
            htp_pkg::SEQ_PMUL:
            begin
                mul_a      = V_W'(q_reg);
                mul_b      = htp_pkg::MUL_B_W'(ACOS_TABLE_ENTRIES);
                state_next = htp_pkg::SEQ_LOOK;
            end
            htp_pkg::SEQ_LOOK:
            begin
                idx_next   = mul_p[TW +: IDX_W];
                f_next     = mul_p[TW-1:0];
                state_next = htp_pkg::SEQ_TAB;
            end
            htp_pkg::SEQ_TAB:
            begin
                lo_next    = curve[idx_reg];
                diff_next  = (hi_point > curve[idx_reg]) ? hi_point - curve[idx_reg] : '0;
                state_next = htp_pkg::SEQ_IMUL;
            end
            htp_pkg::SEQ_IMUL:
            begin
                mul_a      = V_W'(diff_reg);
                mul_b      = f_reg;
                state_next = htp_pkg::SEQ_INTERP;
            end
            htp_pkg::SEQ_INTERP:
            begin
                if (interp_sum > (CW+1)'(htp_pkg::THR_FULL))
                begin
                    thr_next = htp_pkg::THR_FULL;
                end
                else
                begin
                    thr_next = interp_sum[TW-1:0];
                end
                state_next = htp_pkg::SEQ_DONE;
            end
            htp_pkg::SEQ_DONE:
            begin
                if (take)
                begin
                    state_next = htp_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = htp_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign status.idle = (state_reg == htp_pkg::SEQ_IDLE);
    assign status.done = (state_reg == htp_pkg::SEQ_DONE);
    assign result.direction      = dir_reg;
    assign result.throttle_level = thr_reg;

endmodule
